[sv/sadfr_pkg.sv]
package sadfr_pkg;

    localparam int FRAME_BITS       = 16;
    localparam int BIT_CNT_W        = 5;
    localparam int SAMPLE_W         = 12;
    localparam int SAMPLE_LSB       = 3;
    localparam int COUNTER_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONV_WAIT   = 8'd1;

    localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_RESET = 16'd16;
    localparam logic [CFG_DATA_W-1:0] CONV_WAIT_RESET   = 16'd320;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FLUSH = 3'd1,
        PH_WAIT  = 3'd2,
        PH_READ  = 3'd3
    } phase_t;

    // packed from the top down, so cs_n lands in bit 0
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sample_valid;
        logic                busy_res;
        logic                mosi;
        logic                sck;
        logic                cs_n;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[sv/sadfr_cfg_regs.sv]
module sadfr_cfg_regs #(
    parameter int COUNTER_BITS = sadfr_pkg::COUNTER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sadfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sadfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [COUNTER_BITS:0]               half_lim,
    output logic [COUNTER_BITS:0]               wait_lim
);

    localparam int EW = (COUNTER_BITS + 1 > sadfr_pkg::CFG_DATA_W) ?
                        COUNTER_BITS + 1 : sadfr_pkg::CFG_DATA_W;

    // registers hold the effective limit: clipped to the counter span, zero acts as one
    function automatic logic [COUNTER_BITS:0] limit_of(
        input logic [sadfr_pkg::CFG_DATA_W-1:0] v
    );
        logic [EW-1:0] ext;
        logic [EW-1:0] span;
        ext  = EW'(v);
        span = EW'(1) << COUNTER_BITS;
        if (ext > span) ext = span;
        if (ext == '0) ext = EW'(1);
        return ext[COUNTER_BITS:0];
    endfunction

    logic [COUNTER_BITS:0] half_lim_reg;
    logic [COUNTER_BITS:0] wait_lim_reg;
    logic [COUNTER_BITS:0] data_lim;
    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign data_lim  = limit_of(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_lim_reg <= limit_of(sadfr_pkg::HALF_PERIOD_RESET);
            wait_lim_reg <= limit_of(sadfr_pkg::CONV_WAIT_RESET);
        end else if (cfg_write) begin
            if (cfg_index == sadfr_pkg::REG_HALF_PERIOD) half_lim_reg <= data_lim;
            if (cfg_index == sadfr_pkg::REG_CONV_WAIT)   wait_lim_reg <= data_lim;
        end
    end

    assign half_lim = half_lim_reg;
    assign wait_lim = wait_lim_reg;

endmodule

[sv/sadfr_engine.sv]
module sadfr_engine #(
    parameter int COUNTER_BITS = sadfr_pkg::COUNTER_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic                     start_req,
    input  logic                     miso,
    input  logic [COUNTER_BITS:0]    half_lim,
    input  logic [COUNTER_BITS:0]    wait_lim,
    output sadfr_pkg::result_t       result
);

    sadfr_pkg::phase_t phase_reg, phase_next;
    logic [sadfr_pkg::BIT_CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [COUNTER_BITS-1:0]          tick_count_reg, tick_count_next;
    logic [sadfr_pkg::FRAME_BITS-1:0] shift_word_reg, shift_word_next;
    logic [sadfr_pkg::SAMPLE_W-1:0]   sample_hold_reg, sample_hold_next;
    logic                             sck_level_reg, sck_level_next;
    logic                             sample_valid;

    logic [COUNTER_BITS:0] tick_inc;
    logic                  half_hit;
    logic                  wait_hit;
    logic                  frame_done;

    assign tick_inc = {1'b0, tick_count_reg} + (COUNTER_BITS + 1)'(1);
    assign half_hit = !(tick_inc < half_lim);
    assign wait_hit = !(tick_inc < wait_lim);

    // next state
    always_comb begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        tick_count_next  = tick_count_reg;
        shift_word_next  = shift_word_reg;
        sample_hold_next = sample_hold_reg;
        sck_level_next   = sck_level_reg;
        sample_valid     = 1'b0;
        frame_done       = 1'b0;

        case (phase_reg)
            sadfr_pkg::PH_FLUSH, sadfr_pkg::PH_READ: begin
                if (!half_hit) begin
                    tick_count_next = tick_inc[COUNTER_BITS-1:0];
                end else begin
                    tick_count_next = '0;
                    if (!sck_level_reg) begin
                        // rising SCK edge: sample MISO
                        sck_level_next  = 1'b1;
                        shift_word_next = {shift_word_reg[sadfr_pkg::FRAME_BITS-2:0], miso};
                    end else begin
                        sck_level_next = 1'b0;
                        bit_count_next = bit_count_reg + sadfr_pkg::BIT_CNT_W'(1);
                        frame_done     = bit_count_next >=
                                         sadfr_pkg::BIT_CNT_W'(sadfr_pkg::FRAME_BITS);
                    end
                end
                if (frame_done) begin
                    tick_count_next = '0;
                    if (phase_reg == sadfr_pkg::PH_FLUSH) begin
                        phase_next = sadfr_pkg::PH_WAIT;
                    end else begin
                        phase_next       = sadfr_pkg::PH_IDLE;
                        bit_count_next   = '0;
                        sample_valid     = 1'b1;
                        sample_hold_next = shift_word_next[sadfr_pkg::SAMPLE_LSB +:
                                                           sadfr_pkg::SAMPLE_W];
                    end
                end
            end
            sadfr_pkg::PH_WAIT: begin
                if (!wait_hit) begin
                    tick_count_next = tick_inc[COUNTER_BITS-1:0];
                end else begin
                    phase_next      = sadfr_pkg::PH_READ;
                    tick_count_next = '0;
                    bit_count_next  = '0;
                    sck_level_next  = 1'b0;
                    shift_word_next = '0;
                end
            end
            default: begin
                phase_next     = sadfr_pkg::PH_IDLE;
                sck_level_next = 1'b0;
                if (start_req) begin
                    phase_next      = sadfr_pkg::PH_FLUSH;
                    tick_count_next = '0;
                    bit_count_next  = '0;
                    shift_word_next = '0;
                end
            end
        endcase
    end

    // outputs show the state after this tick
    always_comb begin
        result.cs_n         = !(phase_next == sadfr_pkg::PH_FLUSH ||
                                phase_next == sadfr_pkg::PH_READ);
        result.sck          = sck_level_next;
        result.mosi         = 1'b0;
        result.busy_res     = phase_next != sadfr_pkg::PH_IDLE;
        result.sample_valid = sample_valid;
        result.sample       = sample_hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= sadfr_pkg::PH_IDLE;
            bit_count_reg   <= '0;
            tick_count_reg  <= '0;
            shift_word_reg  <= '0;
            sample_hold_reg <= '0;
            sck_level_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            tick_count_reg  <= tick_count_next;
            shift_word_reg  <= shift_word_next;
            sample_hold_reg <= sample_hold_next;
            sck_level_reg   <= sck_level_next;
        end
    end

endmodule

[sv/spi_adc_double_frame_reader.sv]
// SPI mode 0 master for a 12-bit serial converter. Every input word is one
// tick (start_req, miso); every accepted word yields exactly one output word
// with the pin levels and state after that tick. A start while idle clocks a
// flush frame, holds chip select high for the conversion wait, then clocks the
// read frame; bits 14..3 of it become the sample, flagged by sample_valid for
// one word. One word is taken per clock while the output register can take it:
// the tick is worked out in a single pass from the state registers and lands in
// the output register, and a new word is taken whenever that register is empty
// or being drained. Configuration writes take effect at once.
module spi_adc_double_frame_reader #(
    parameter int COUNTER_BITS = sadfr_pkg::COUNTER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sadfr_pkg::S_TDATA_W-1:0]     s_tdata,  // start_req, miso, zero pad

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cs_n, sck, mosi, busy_res, sample_valid, sample[11:0], zero pad
    output logic [sadfr_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sadfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sadfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [COUNTER_BITS:0] half_lim;
    logic [COUNTER_BITS:0] wait_lim;
    sadfr_pkg::result_t    result;
    sadfr_pkg::result_t    m_res_reg;
    logic                  m_tvalid_reg;
    logic                  s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    sadfr_cfg_regs #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .half_lim  (half_lim),
        .wait_lim  (wait_lim)
    );

    sadfr_engine #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_accept),
        .start_req (s_tdata[0]),
        .miso      (s_tdata[1]),
        .half_lim  (half_lim),
        .wait_lim  (wait_lim),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(sadfr_pkg::M_TDATA_W - sadfr_pkg::RESULT_W)'(0), m_res_reg};

    a_word_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted word gave no output word");

    a_mosi_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_res_reg.mosi)
        else $error("mosi driven high");

    a_valid_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res_reg.sample_valid) |->
            (!m_res_reg.busy_res && m_res_reg.cs_n && !m_res_reg.sck))
        else $error("sample flagged while sequence still running");

    a_idle_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_res_reg.busy_res) |-> (m_res_reg.cs_n && !m_res_reg.sck))
        else $error("bus active while idle");

endmodule
